// ===== src/binary_morphology_erode_dilate_macros.svh =====
// Assertion macros shared by the checker files of the binary morphology block.
// No dependencies; include by bare file name.
`ifndef BINARY_MORPHOLOGY_ERODE_DILATE_MACROS_SVH
`define BINARY_MORPHOLOGY_ERODE_DILATE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BMED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// Condition must never occur outside reset.
`define BMED_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== src/bmed_pkg.sv =====
// Package of the binary morphology block: sizes, register codes, shared types
// and the column mask function. No dependencies.
package bmed_pkg;

  localparam int RowWidth  = 64;  // pixel columns per row, range 5 to 64
  localparam int HistDepth = 4;   // stored rows above the newest
  localparam int NumWin    = HistDepth + 1;
  localparam int SeenW     = $clog2(HistDepth + 1);
  localparam int WidthW    = 7;   // active_width register
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;
  localparam int PosW      = 2;   // centre row position 0..2 in the window
  localparam int NumEmit   = 3;   // results one row can cause

  typedef logic [RowWidth-1:0] row_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegOperation   = 2'd0,
    RegKernelShape = 2'd1,
    RegActiveWidth = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OpErode  = 1'b0,
    OpDilate = 1'b1
  } op_e;

  typedef enum logic {
    ShapeCross   = 1'b0,
    ShapeDiamond = 1'b1
  } shape_e;

  typedef struct packed {
    op_e    op;
    shape_e shape;
    row_t   mask;
  } cfg_t;

  // rows[0] is the newest row, rows[i] the row i places above it
  typedef struct packed {
    logic [NumWin-1:0][RowWidth-1:0] rows;
    logic [SeenW-1:0]                seen;
  } win_t;

  function automatic row_t col_mask(input logic [WidthW-1:0] width);
    row_t m;
    int   wc;
    wc = int'(width);
    if (wc > RowWidth) wc = RowWidth;
    for (int i = 0; i < RowWidth; i++) m[i] = (i < wc);
    return m;
  endfunction

endpackage

// ===== src/bmed_history.sv =====
// Row history of the binary morphology block: four stored rows and the
// per-frame row count. Depends on bmed_pkg.
module bmed_history (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [bmed_pkg::RowWidth-1:0]  row_bits_i,
  input  logic                           final_row_i,
  input  logic [bmed_pkg::RowWidth-1:0]  mask_i,
  output bmed_pkg::win_t                 win_o
);
  import bmed_pkg::*;

  logic [HistDepth-1:0][RowWidth-1:0] hist_q, hist_d;
  logic [SeenW-1:0]                   seen_q, seen_d;

  always_comb begin
    win_o.rows[0] = row_bits_i & mask_i;
    for (int i = 0; i < HistDepth; i++) win_o.rows[i+1] = hist_q[i];
    win_o.seen = seen_q;

    hist_d = hist_q;
    seen_d = seen_q;
    if (accept_i) begin
      if (final_row_i) begin
        hist_d = '0;
        seen_d = '0;
      end else begin
        for (int i = 0; i < HistDepth; i++) hist_d[i] = win_o.rows[i];
        seen_d = (seen_q < SeenW'(HistDepth)) ? seen_q + 1'b1 : SeenW'(HistDepth);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      seen_q <= '0;
    end else begin
      hist_q <= hist_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== src/bmed_filter.sv =====
// Bitwise erode/dilate kernel of the binary morphology block for one centre
// row of a five-row window. Depends on bmed_pkg.
module bmed_filter (
  input  bmed_pkg::win_t                 win_i,
  input  logic [bmed_pkg::PosW-1:0]      pos_i,
  input  bmed_pkg::cfg_t                 cfg_i,
  output logic [bmed_pkg::RowWidth-1:0]  res_o
);
  import bmed_pkg::*;

  row_t r [NumWin];
  row_t acc;
  logic dil;

  // Dilation runs as erosion of the complement with outside pixels set.
  always_comb begin : prep
    int         idx;
    logic       ok;
    logic [2:0] sel;
    row_t       v;
    dil = (cfg_i.op == OpDilate);
    for (int j = 0; j < NumWin; j++) begin
      idx = int'(pos_i) + 2 - j;
      ok  = (idx >= 0) && (idx <= int'(win_i.seen));
      sel = ok ? 3'(idx) : 3'd0;
      v   = ok ? (dil ? ~win_i.rows[sel] : win_i.rows[sel]) : '1;
      r[j] = (v & cfg_i.mask) | ~cfg_i.mask;
    end
  end

  // Vacated columns of each shift read as set.
  always_comb begin
    acc = r[2] & {r[2][RowWidth-2:0], 1'b1} & {1'b1, r[2][RowWidth-1:1]} & r[1] & r[3];
    if (cfg_i.shape == ShapeDiamond) begin
      acc = acc & {r[2][RowWidth-3:0], 2'b11} & {2'b11, r[2][RowWidth-1:2]};
      acc = acc & {r[1][RowWidth-2:0], 1'b1} & {1'b1, r[1][RowWidth-1:1]};
      acc = acc & {r[3][RowWidth-2:0], 1'b1} & {1'b1, r[3][RowWidth-1:1]};
      acc = acc & r[0] & r[4];
    end
    res_o = (dil ? ~acc : acc) & cfg_i.mask;
  end

endmodule

// ===== src/binary_morphology_erode_dilate.sv =====
// Binary erosion / dilation of a row-serial image, 5-point cross or 13-point
// diamond kernel. Sustained rate is one row per clock: a row is taken every
// cycle while the output side drains and no flush is under way. Each row with
// two earlier rows in its frame is answered by the filtered row two rows above
// it, so results trail the input by two rows. The row flagged final_row flushes
// the frame and yields up to three result beats; these go out one per cycle,
// unless the output stalls, through the single kernel unit and output register,
// so the input stalls after a final row until they drain. A result beat goes
// through the job and output registers. Pixels outside the map (above the
// frame, beyond the column edges or the active width) count as set for erosion
// and clear for dilation; result columns at or beyond active_width read zero.
// After a final row the history clears, so the next beat starts a new frame.
// Configuration (operation, kernel_shape, active_width) is written through the
// cfg port, always ready, and must only change while no row is in flight.
// Depends on bmed_pkg, bmed_history and bmed_filter.
module binary_morphology_erode_dilate (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input rows
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bmed_pkg::RowWidth-1:0]  row_bits_i,
  input  logic                           final_row_i,
  // filtered rows
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bmed_pkg::RowWidth-1:0]  result_bits_o,
  output logic                           frame_end_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bmed_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bmed_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bmed_pkg::*;

  // Configuration registers
  op_e               op_q;
  shape_e            shape_q;
  logic [WidthW-1:0] width_q;
  cfg_t              cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OpErode;
      shape_q <= ShapeCross;
      width_q <= WidthW'(RowWidth);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegOperation:   op_q    <= op_e'(cfg_data_i[0]);
        RegKernelShape: shape_q <= shape_e'(cfg_data_i[0]);
        RegActiveWidth: width_q <= cfg_data_i[WidthW-1:0];
        default: ;  // write beyond the register list: drop
      endcase
    end
  end

  assign cfg.op    = op_q;
  assign cfg.shape = shape_q;
  assign cfg.mask  = col_mask(width_q);

  // Input beat and row history
  logic in_acc;
  win_t win_now;

  assign in_acc = in_valid_i && !in_stall_o;

  bmed_history u_history (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .row_bits_i  (row_bits_i),
    .final_row_i (final_row_i),
    .mask_i      (cfg.mask),
    .win_o       (win_now)
  );

  // Job register: window snapshot plus one pending bit per centre position.
  // Bit k set means the result centred k rows above the newest still has to
  // go out; positions leave in the order 2, 1, 0.
  win_t               job_win_q;
  logic [NumEmit-1:0] pend_q, pend_d, pend_load, pend_after;
  logic [PosW-1:0]    cur_pos;
  logic               has_job, out_free, fire;
  row_t               filt;

  always_comb begin
    pend_load[2] = (win_now.seen >= SeenW'(2));
    pend_load[1] = final_row_i && (win_now.seen >= SeenW'(1));
    pend_load[0] = final_row_i;
  end

  assign cur_pos    = pend_q[2] ? PosW'(2) : (pend_q[1] ? PosW'(1) : PosW'(0));
  assign pend_after = pend_q & ~(NumEmit'(1) << cur_pos);
  assign has_job    = |pend_q;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign fire       = has_job && out_free;
  // Take a new row once the job register empties, this cycle at the latest.
  assign in_stall_o = has_job && !(fire && (pend_after == '0));

  always_comb begin
    pend_d = pend_q;
    if (in_acc)    pend_d = pend_load;
    else if (fire) pend_d = pend_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else         pend_q <= pend_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) job_win_q <= win_now;
  end

  bmed_filter u_filter (
    .win_i (job_win_q),
    .pos_i (cur_pos),
    .cfg_i (cfg),
    .res_o (filt)
  );

  // Output register: load on fire, drop the beat once taken.
  logic out_valid_q, out_valid_d;
  row_t result_q;
  logic frame_end_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire)          out_valid_d = 1'b1;
    else if (out_free) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q    <= filt;
      frame_end_q <= (cur_pos == PosW'(0));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_bits_o = result_q;
  assign frame_end_o   = frame_end_q;

endmodule

// ===== src/bmed_checker.sv =====
// Port-level checks of binary_morphology_erode_dilate and the bind that
// attaches them. Depends on bmed_pkg and the assertion macro header.
`include "binary_morphology_erode_dilate_macros.svh"

module bmed_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [bmed_pkg::RowWidth-1:0]  result_bits_o,
  input logic                           frame_end_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [bmed_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [bmed_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bmed_pkg::*;

  // Shadow of the active width as seen on the cfg port
  logic [WidthW-1:0] width_q;
  logic              free_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(RowWidth);
    end else if (cfg_valid_i && cfg_ready_o
                 && (cfg_reg_e'(cfg_index_i) == RegActiveWidth)) begin
      width_q <= cfg_data_i[WidthW-1:0];
    end
  end

  assign free_stall = in_stall_o && !out_stall_i;

  // A held result beat keeps its payload.
  `BMED_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_bits_o) && $stable(frame_end_o))

  // Columns beyond the active width read zero.
  `BMED_ASSERT(a_cols_clear, clk_i, rst_ni, out_valid_o |-> ((result_bits_o & ~col_mask(width_q)) == '0))

  // A flush ends its input stall as its beats drain through a free output.
  `BMED_ASSERT_NEVER(a_flush_len, clk_i, rst_ni, free_stall && $past(free_stall) && $past(free_stall, 2))

endmodule

bind binary_morphology_erode_dilate bmed_checker u_bmed_checker (.*);

// ===== dv/morph_row_checker.sv =====
`timescale 1ns / 100ps
// Checker for the binary morphology block: watches the row, result and register channels,
// predicts each filtered row and compares it with what the block sends. Needs bmed_pkg.
module morph_row_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [bmed_pkg::RowWidth-1:0]  row_bits_i,
  input  logic                           final_row_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [bmed_pkg::RowWidth-1:0]  result_bits_i,
  input  logic                           frame_end_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bmed_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bmed_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                             mismatch_count_o,
  output int                             rows_pending_o,
  output int                             beats_checked_o
);
  import bmed_pkg::*;

  typedef struct packed {
    row_t bits;
    logic frame_end;
  } filt_row_t;

  filt_row_t         expected_rows [$];
  row_t              row_store [HistDepth];
  int                rows_held;
  op_e               op_q;
  shape_e            shape_q;
  logic [WidthW-1:0] width_q;

  function automatic row_t width_mask(input logic [WidthW-1:0] w);
    if (w >= RowWidth) return ~row_t'(0);
    return (row_t'(1) << w) - row_t'(1);
  endfunction

  // shifts that fill the vacated columns with set pixels
  function automatic row_t fill_up(input row_t v, input int k);
    return (v << k) | ((row_t'(1) << k) - row_t'(1));
  endfunction

  function automatic row_t fill_down(input row_t v, input int k);
    row_t ones;
    ones = ~row_t'(0);
    return (v >> k) | ~(ones >> k);
  endfunction

  // dilation is erosion of the complement, with outside pixels set
  function automatic row_t kernel_row(input row_t win [5], input bit ok [5], input row_t m);
    row_t r [5];
    row_t acc;
    logic dil;
    dil = (op_q == OpDilate);
    for (int j = 0; j < 5; j++) begin
      r[j] = ok[j] ? (dil ? ~win[j] : win[j]) : ~row_t'(0);
      r[j] = (r[j] & m) | ~m;
    end
    acc = r[2] & fill_up(r[2], 1) & fill_down(r[2], 1) & r[1] & r[3];
    if (shape_q == ShapeDiamond) begin
      acc &= fill_up(r[2], 2) & fill_down(r[2], 2);
      acc &= fill_up(r[1], 1) & fill_down(r[1], 1);
      acc &= fill_up(r[3], 1) & fill_down(r[3], 1);
      acc &= r[0] & r[4];
    end
    if (dil) acc = ~acc;
    return acc & m;
  endfunction

  // centre row sits p rows above the newest; rows above the frame top are outside
  function automatic row_t filter_at(input row_t rows [5], input int seen, input int p,
                                     input row_t m);
    row_t win [5];
    bit   ok [5];
    int   idx;
    for (int dy = -2; dy <= 2; dy++) begin
      idx = p - dy;
      ok[dy + 2]  = (idx >= 0) && (idx <= 4) && (idx <= seen);
      win[dy + 2] = ok[dy + 2] ? rows[idx] : '0;
    end
    return kernel_row(win, ok, m);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    row_t      rows [5];
    row_t      m;
    filt_row_t want;
    int        n;
    if (!rst_ni) begin
      op_q             = OpErode;
      shape_q          = ShapeCross;
      width_q          = WidthW'(RowWidth);
      rows_held        = 0;
      mismatch_count_o = 0;
      beats_checked_o  = 0;
      for (int i = 0; i < HistDepth; i++) row_store[i] = '0;
      expected_rows.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegOperation:   op_q    = op_e'(cfg_data_i[0]);
          RegKernelShape: shape_q = shape_e'(cfg_data_i[0]);
          RegActiveWidth: width_q = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        m       = width_mask(width_q);
        n       = rows_held;
        rows[0] = row_bits_i & m;
        for (int i = 0; i < HistDepth; i++) rows[i + 1] = row_store[i];
        if (n >= 2) expected_rows.push_back('{filter_at(rows, n, 2, m), 1'b0});
        if (final_row_i) begin
          if (n >= 1) expected_rows.push_back('{filter_at(rows, n, 1, m), 1'b0});
          expected_rows.push_back('{filter_at(rows, n, 0, m), 1'b1});
          // frame closed: drop the history
          for (int i = 0; i < HistDepth; i++) row_store[i] = '0;
          rows_held = 0;
        end else begin
          for (int i = 0; i < HistDepth; i++) row_store[i] = rows[i];
          rows_held = (n < HistDepth) ? n + 1 : HistDepth;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        beats_checked_o++;
        if (expected_rows.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result beat with nothing expected: expected none, actual %h/%b",
                   $time, result_bits_i, frame_end_i);
        end else begin
          want = expected_rows.pop_front();
          if (result_bits_i !== want.bits) begin
            mismatch_count_o++;
            $display("%0t: result_bits mismatch: expected %h, actual %h",
                     $time, want.bits, result_bits_i);
          end
          if (frame_end_i !== want.frame_end) begin
            mismatch_count_o++;
            $display("%0t: frame_end mismatch: expected %b, actual %b",
                     $time, want.frame_end, frame_end_i);
          end
        end
      end
    end
    rows_pending_o = expected_rows.size();
  end

endmodule

// ===== dv/tb_binary_morphology_erode_dilate.sv =====
`timescale 1ns / 100ps
// Top of the binary morphology testbench: clock, reset, row stimulus, result stalls and
// verdict. Needs bmed_pkg, the block itself and morph_row_checker.
module tb_binary_morphology_erode_dilate;
  import bmed_pkg::*;

  localparam int   RandomRows = 140;
  localparam int   SettleCyc  = 8;    // a flush takes up to three beats; leave margin
  localparam int   HoldCyc    = 80;   // long receiver hold-off
  // longest quiet stretch: the hold-off plus a full pipeline, several times over
  localparam int   IdleLimit  = 2000;
  localparam row_t AllSet     = ~row_t'(0);
  // register index that maps to nothing in the block
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  row_t                 row_bits_i;
  logic                 final_row_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  row_t                 result_bits_o;
  logic                 frame_end_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  int mismatch_count;
  int rows_pending;
  int beats_checked;
  int rows_sent   = 0;
  int frames_sent = 0;
  int reg_writes  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;

  always #5 clk_i = ~clk_i;

  binary_morphology_erode_dilate dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .row_bits_i, .final_row_i,
    .out_valid_o, .out_stall_i, .result_bits_o, .frame_end_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  morph_row_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .row_bits_i, .final_row_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_bits_i(result_bits_o),
    .frame_end_i(frame_end_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatch_count),
    .rows_pending_o(rows_pending),
    .beats_checked_o(beats_checked)
  );

  // Offer one row beat. The sender runs in bursts: when a burst is used up, drop valid
  // for a random gap, sometimes none, and start a new one. Valid stays high across a burst.
  task automatic offer_row(input row_t bits, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    row_bits_i  <= bits;
    final_row_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    rows_sent++;
    if (fin) frames_sent++;
  endtask

  // Drop valid, wait for every expected result, then let a started flush finish.
  task automatic drain_rows();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (rows_pending != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    reg_writes++;
  endtask

  // sel bits: operation, kernel shape, active width, spare index
  task automatic configure(input logic [3:0] sel, input logic [CfgDataW-1:0] op_d,
                           input logic [CfgDataW-1:0] shape_d,
                           input logic [CfgDataW-1:0] width_d,
                           input logic [CfgDataW-1:0] spare_d);
    if (sel[0]) write_reg(RegOperation, op_d);
    if (sel[1]) write_reg(RegKernelShape, shape_d);
    if (sel[2]) write_reg(RegActiveWidth, width_d);
    if (sel[3]) write_reg(RegSpare, spare_d);
    cfg_valid_i <= 1'b0;
  endtask

  // Mix of empty, full, dense and sparse rows so both erosion and dilation see
  // something other than all-zero or all-one results.
  function automatic row_t pick_row();
    row_t a;
    row_t b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return AllSet;
      2, 3:    return a | b | {$urandom, $urandom};
      4, 5:    return a & b;
      default: return a;
    endcase
  endfunction

  // Mostly full width, some narrow, zero now and then, and values past full width.
  function automatic logic [CfgDataW-1:0] pick_width();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CfgDataW'(RowWidth);
      4, 5:       return CfgDataW'($urandom_range(1, 8));
      6, 7:       return CfgDataW'($urandom_range(1, RowWidth));
      8:          return '0;
      default:    return CfgDataW'($urandom_range(RowWidth + 1, 127));
    endcase
  endfunction

  // Receiver stalls: segments of random density, including stall-free stretches, plus
  // a long hold-off whenever the stimulus asks for one.
  initial begin : result_stalls
    int hold_left;
    int seg_left;
    int stall_pct;
    hold_left = 0;
    seg_left  = 0;
    stall_pct = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCyc;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 60);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("%0t: watchdog: no beat accepted for %0d cycles", $time, IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int  rand_first;
    int  phase;
    int  n_frames;
    int  len;
    bit  open_frame;
    bit  long_phase;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    row_bits_i  <= '0;
    final_row_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= RegOperation;
    cfg_data_i  <= '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: reset settings (erode, cross, full width). One-row, two-row and
    // five-row frames; holes at the first and last column probe the edges.
    offer_row(AllSet, 1'b1);
    offer_row(AllSet, 1'b0);
    offer_row(AllSet, 1'b1);
    offer_row(AllSet, 1'b0);
    offer_row(~row_t'(1), 1'b0);
    offer_row(AllSet >> 1, 1'b0);
    offer_row(AllSet, 1'b0);
    offer_row(AllSet, 1'b1);

    // dilate with the diamond: single pixels at both edge columns
    drain_rows();
    configure(4'b0011, CfgDataW'(OpDilate), CfgDataW'(ShapeDiamond), '0, '0);
    offer_row(row_t'(1), 1'b0);
    offer_row('0, 1'b0);
    offer_row(row_t'(1) << (RowWidth - 1), 1'b0);
    offer_row('0, 1'b0);
    offer_row('0, 1'b1);

    // one column in use: everything beyond it must be ignored and read zero
    drain_rows();
    configure(4'b0101, CfgDataW'(OpErode), '0, 7'd1, '0);
    offer_row(AllSet, 1'b0);
    offer_row(AllSet, 1'b0);
    offer_row(AllSet, 1'b1);

    // zero width gives all-zero results; also hit the unused register index
    drain_rows();
    configure(4'b1111, CfgDataW'(OpDilate), CfgDataW'(ShapeCross), '0, 7'h55);
    offer_row(AllSet, 1'b0);
    offer_row(AllSet, 1'b1);

    // width past the row size saturates at full width
    drain_rows();
    configure(4'b0101, CfgDataW'(OpErode), '0, 7'd100, '0);
    offer_row(AllSet, 1'b0);
    offer_row(~(row_t'(1) << 40), 1'b0);
    offer_row(AllSet, 1'b1);

    // operation changes in the middle of a frame of width 10
    drain_rows();
    configure(4'b0100, '0, '0, 7'd10, '0);
    offer_row(AllSet, 1'b0);
    offer_row(AllSet, 1'b0);
    drain_rows();
    configure(4'b0001, CfgDataW'(OpDilate), '0, '0, '0);
    offer_row('0, 1'b0);
    offer_row('0, 1'b1);

    // Random phases: fresh settings, then one to three frames. Two phases carry long
    // frames and ask for the receiver hold-off so the block fills and stalls its input.
    // The last frame of a phase is sometimes left open across the settings change.
    rand_first = rows_sent;
    phase      = 0;
    while (rows_sent - rand_first < RandomRows) begin
      drain_rows();
      configure({1'b0, 3'($urandom_range(1, 7))}, CfgDataW'($urandom_range(0, 127)),
                CfgDataW'($urandom_range(0, 127)), pick_width(), '0);
      long_phase = (phase == 0) || (phase == 6);
      if (long_phase) hold_req = 1'b1;
      n_frames = long_phase ? 3 : $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: len = $urandom_range(1, 2);
          3, 4, 5: len = $urandom_range(9, 16);
          default: len = $urandom_range(3, 8);
        endcase
        if (long_phase) len = $urandom_range(12, 16);
        open_frame = !long_phase && (f == n_frames - 1) && ($urandom_range(0, 4) == 0);
        for (int r = 0; r < len; r++) offer_row(pick_row(), (r == len - 1) && !open_frame);
      end
      phase++;
    end

    drain_rows();
    repeat (20) @(negedge clk_i);

    $display("Run covered %0d rows in %0d closed frames, %0d register writes, %0d results checked.",
             rows_sent, frames_sent, reg_writes, beats_checked);
    $display("Settings spanned erode and dilate, cross and diamond, widths from zero past full.");
    if (mismatch_count == 0 && rows_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bmed_pkg.sv
src/bmed_history.sv
src/bmed_filter.sv
src/binary_morphology_erode_dilate.sv
src/bmed_checker.sv
dv/morph_row_checker.sv
dv/tb_binary_morphology_erode_dilate.sv
